/* src/fel_pkg.sv */
// ----------------------------------------------------------------------------
// fel_pkg: shared types and constants of the free extent list manager
// Status codes, default sizes and the control groups handed to the cell row.
// ----------------------------------------------------------------------------
package fel_pkg;

  localparam int DEF_MAX_EXTENTS  = 64;
  localparam int DEF_ADDRESS_BITS = 24;
  localparam int STATUS_W         = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERRUN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } shift_op_t;

  // phase strobes from the sequencer to every cell
  typedef struct packed {
    logic init;
    logic cmp;
    logic apply;
  } cell_ctl_t;

  // update command for one request
  typedef struct packed {
    logic      wr_en;
    shift_op_t op;
  } cell_cmd_t;

endpackage

/* src/free_extent_list_manager.sv */
// ----------------------------------------------------------------------------
// free_extent_list_manager: first-fit free list with coalescing
// Sorted row of extent cells; allocate carves, free merges or inserts.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  request  | start / busy           | in_kind, in_start_address, in_region_length
//  result   | out_valid strobe       | out_status, out_free_extent_count
//  config   | cfg_valid / cfg_ready  | cfg_memory_size
//
// The result strobe comes in S_APPLY, after S_CMP, where every cell compares in
// parallel, and S_SEL, where the first match is picked and the update formed;
// at the end of the strobe cycle the row shifts or writes. busy is high from
// acceptance through the strobe, so a new request is taken only after it.
// Reset loads the table with one extent (0, 2**ADDRESS_BITS), a config write
// with one extent (0, memory_size). Results cannot be stalled.
module free_extent_list_manager #(
  parameter int MAX_EXTENTS  = fel_pkg::DEF_MAX_EXTENTS,
  parameter int ADDRESS_BITS = fel_pkg::DEF_ADDRESS_BITS,
  parameter int CW           = $clog2(MAX_EXTENTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [ADDRESS_BITS-1:0]      in_start_address,
  input  logic [ADDRESS_BITS:0]        in_region_length,
  output logic                         out_valid,
  output logic [fel_pkg::STATUS_W-1:0] out_status,
  output logic [CW-1:0]                out_free_extent_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ADDRESS_BITS:0]        cfg_memory_size
);

  localparam int N  = MAX_EXTENTS;
  localparam int AW = ADDRESS_BITS;
  localparam int LW = AW + 1;
  localparam int EW = AW + 2;
  localparam int IW = $clog2(N);
  localparam logic [LW-1:0] LMASK = '1;
  localparam logic [LW-1:0] DEF_SIZE = LW'(1) << AW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_SEL   = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic          kind_r;
  logic [AW-1:0] s_r;
  logic [LW-1:0] l_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [fel_pkg::STATUS_W-1:0] status_r, status_nxt;

  fel_pkg::cell_cmd_t cmd_r, cmd_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt, op_idx_r, op_idx_nxt;
  logic [AW-1:0] wr_start_r, wr_start_nxt, ins_start_r, ins_start_nxt;
  logic [LW-1:0] wr_len_r, wr_len_nxt, ins_len_r, ins_len_nxt;

  fel_pkg::cell_ctl_t ctl;
  logic [LW-1:0] init_len;
  logic cfg_wr, accept;

  logic [AW-1:0] c_start [N+1];
  logic [LW-1:0] c_len   [N+1];
  logic [N:0]    found;
  logic [N-1:0]  sel;
  logic [N-1:0]  valid;
  logic [N-1:0]  last;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign init_len  = rst_n ? cfg_memory_size : DEF_SIZE;

  assign ctl.init  = !rst_n || cfg_wr;
  assign ctl.cmp   = (state_r == S_CMP);
  assign ctl.apply = (state_r == S_APPLY);

  assign found[0]   = 1'b0;
  assign c_start[N] = '0;
  assign c_len[N]   = '0;

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic [AW-1:0] p_start;
    logic [LW-1:0] p_len;
    if (j == 0) begin : g_first
      assign p_start = '0;
      assign p_len   = '0;
    end else begin : g_rest
      assign p_start = c_start[j-1];
      assign p_len   = c_len[j-1];
    end
    assign valid[j] = (CW'(j) < count_r);
    if (j == N - 1) begin : g_end
      assign last[j] = valid[j];
    end else begin : g_mid
      assign last[j] = valid[j] && !(CW'(j + 1) < count_r);
    end

    fel_cell #(.AW(AW), .IW(IW), .IDX(j)) u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .init_len_i  (init_len),
      .kind_i      (kind_r),
      .s_i         (s_r),
      .l_i         (l_r),
      .valid_i     (valid[j]),
      .prev_start_i(p_start),
      .prev_len_i  (p_len),
      .next_start_i(c_start[j+1]),
      .next_len_i  (c_len[j+1]),
      .found_i     (found[j]),
      .found_o     (found[j+1]),
      .sel_o       (sel[j]),
      .start_o     (c_start[j]),
      .len_o       (c_len[j]),
      .cmd_i       (cmd_r),
      .wr_idx_i    (wr_idx_r),
      .wr_start_i  (wr_start_r),
      .wr_len_i    (wr_len_r),
      .op_idx_i    (op_idx_r),
      .ins_start_i (ins_start_r),
      .ins_len_i   (ins_len_r)
    );
  end

  // gather the selected extent, its predecessor and the last extent
  logic [AW-1:0] cs, ps, ls;
  logic [LW-1:0] cl, pl, ll;
  logic [IW-1:0] idx;
  logic          any;

  always_comb begin
    cs = '0; cl = '0; ps = '0; pl = '0; ls = '0; ll = '0; idx = '0;
    for (int j = 0; j < N; j++) begin
      if (sel[j]) begin
        cs  = cs | c_start[j];
        cl  = cl | c_len[j];
        idx = idx | IW'(j);
        if (j > 0) begin
          ps = ps | c_start[j-1];
          pl = pl | c_len[j-1];
        end
      end
      if (last[j]) begin
        ls = ls | c_start[j];
        ll = ll | c_len[j];
      end
    end
  end

  assign any = found[N];

  logic [EW-1:0] s_ext, sl, ce, pe, le;
  logic [EW:0]   sum3;
  logic [EW-1:0] sum_p, sum_c, sum_l;
  logic          full, mprev, mnext;

  assign s_ext = {2'b00, s_r};
  assign sl    = s_ext + {1'b0, l_r};
  assign ce    = {2'b00, cs} + {1'b0, cl};
  assign pe    = {2'b00, ps} + {1'b0, pl};
  assign le    = {2'b00, ls} + {1'b0, ll};
  assign sum3  = {2'b00, pl} + {2'b00, l_r} + {2'b00, cl};
  assign sum_p = {1'b0, pl} + {1'b0, l_r};
  assign sum_c = {1'b0, cl} + {1'b0, l_r};
  assign sum_l = {1'b0, ll} + {1'b0, l_r};
  assign full  = (count_r == CW'(N));
  assign mprev = (idx != '0) && (s_ext == pe);
  assign mnext = (sl == {2'b00, cs});

  always_comb begin
    cmd_nxt.wr_en = 1'b0;
    cmd_nxt.op    = fel_pkg::OP_NONE;
    wr_idx_nxt    = idx;
    wr_start_nxt  = cs;
    wr_len_nxt    = cl;
    op_idx_nxt    = idx;
    ins_start_nxt = s_r;
    ins_len_nxt   = l_r;
    status_nxt    = fel_pkg::ST_OK;
    count_nxt     = count_r;
    if (kind_r == fel_pkg::KIND_ALLOC) begin
      priority if (!any) begin
        status_nxt = fel_pkg::ST_MISS;
      end else if (ce < sl) begin
        status_nxt = fel_pkg::ST_OVERRUN;
      end else if (s_r == cs && l_r == cl) begin
        cmd_nxt.op = fel_pkg::OP_DEL;
        count_nxt  = count_r - CW'(1);
      end else if (s_r == cs) begin
        cmd_nxt.wr_en = 1'b1;
        wr_start_nxt  = sl[AW-1:0];
        wr_len_nxt    = cl - l_r;
      end else if (sl == ce) begin
        cmd_nxt.wr_en = 1'b1;
        wr_len_nxt    = {1'b0, AW'(s_r - cs)};
      end else if (full) begin
        status_nxt = fel_pkg::ST_FULL;
      end else begin
        cmd_nxt.wr_en = 1'b1;
        wr_len_nxt    = {1'b0, AW'(s_r - cs)};
        cmd_nxt.op    = fel_pkg::OP_INS;
        op_idx_nxt    = idx + IW'(1);
        ins_start_nxt = sl[AW-1:0];
        ins_len_nxt   = LW'(ce - sl);
        count_nxt     = count_r + CW'(1);
      end
    end else if (any) begin
      priority if (mprev && mnext) begin
        cmd_nxt.wr_en = 1'b1;
        wr_idx_nxt    = idx - IW'(1);
        wr_start_nxt  = ps;
        wr_len_nxt    = (sum3 > {2'b00, LMASK}) ? LMASK : sum3[LW-1:0];
        cmd_nxt.op    = fel_pkg::OP_DEL;
        count_nxt     = count_r - CW'(1);
      end else if (mprev) begin
        cmd_nxt.wr_en = 1'b1;
        wr_idx_nxt    = idx - IW'(1);
        wr_start_nxt  = ps;
        wr_len_nxt    = (sum_p > {1'b0, LMASK}) ? LMASK : sum_p[LW-1:0];
      end else if (mnext) begin
        cmd_nxt.wr_en = 1'b1;
        wr_start_nxt  = s_r;
        wr_len_nxt    = (sum_c > {1'b0, LMASK}) ? LMASK : sum_c[LW-1:0];
      end else if (full) begin
        status_nxt = fel_pkg::ST_FULL;
      end else begin
        cmd_nxt.op = fel_pkg::OP_INS;
        count_nxt  = count_r + CW'(1);
      end
    end else begin
      // no gap fits: extend or append after the last extent, else report full
      priority if (count_r != '0 && s_ext == le) begin
        cmd_nxt.wr_en = 1'b1;
        wr_idx_nxt    = IW'(count_r - CW'(1));
        wr_start_nxt  = ls;
        wr_len_nxt    = (sum_l > {1'b0, LMASK}) ? LMASK : sum_l[LW-1:0];
      end else if (full) begin
        status_nxt = fel_pkg::ST_FULL;
      end else begin
        cmd_nxt.op = fel_pkg::OP_INS;
        op_idx_nxt = IW'(count_r);
        count_nxt  = count_r + CW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
      cmd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        count_r <= CW'(1);
      end else if (state_r == S_SEL) begin
        count_r <= count_nxt;
      end
      if (state_r == S_SEL) begin
        cmd_r <= cmd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      s_r    <= in_start_address;
      l_r    <= in_region_length;
    end
    if (state_r == S_SEL) begin
      status_r    <= status_nxt;
      wr_idx_r    <= wr_idx_nxt;
      wr_start_r  <= wr_start_nxt;
      wr_len_r    <= wr_len_nxt;
      op_idx_r    <= op_idx_nxt;
      ins_start_r <= ins_start_nxt;
      ins_len_r   <= ins_len_nxt;
    end
  end

  assign out_valid             = (state_r == S_APPLY);
  assign out_status            = status_r;
  assign out_free_extent_count = count_r;

endmodule

/* src/fel_cell.sv */
// ----------------------------------------------------------------------------
// fel_cell: one slot of the free extent table
// Holds one extent, flags whether it matches the pending request, and takes
// its neighbor's extent when the table shifts for an insert or a removal.
// ----------------------------------------------------------------------------
module fel_cell #(
  parameter int AW  = fel_pkg::DEF_ADDRESS_BITS,
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  fel_pkg::cell_ctl_t  ctl_i,
  input  logic [AW:0]         init_len_i,
  input  logic                kind_i,
  input  logic [AW-1:0]       s_i,
  input  logic [AW:0]         l_i,
  input  logic                valid_i,
  input  logic [AW-1:0]       prev_start_i,
  input  logic [AW:0]         prev_len_i,
  input  logic [AW-1:0]       next_start_i,
  input  logic [AW:0]         next_len_i,
  input  logic                found_i,
  output logic                found_o,
  output logic                sel_o,
  output logic [AW-1:0]       start_o,
  output logic [AW:0]         len_o,
  input  fel_pkg::cell_cmd_t  cmd_i,
  input  logic [IW-1:0]       wr_idx_i,
  input  logic [AW-1:0]       wr_start_i,
  input  logic [AW:0]         wr_len_i,
  input  logic [IW-1:0]       op_idx_i,
  input  logic [AW-1:0]       ins_start_i,
  input  logic [AW:0]         ins_len_i
);

  localparam int EW = AW + 2;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [AW-1:0] start_r;
  logic [AW:0]   len_r;
  logic          hit_r;
  logic          hit_nxt;
  logic [EW-1:0] end_w;
  logic [EW-1:0] prev_end_w;
  logic [EW-1:0] sl_w;
  logic [EW-1:0] s_ext;

  assign end_w      = {2'b00, start_r} + {1'b0, len_r};
  assign prev_end_w = {2'b00, prev_start_i} + {1'b0, prev_len_i};
  assign s_ext      = {2'b00, s_i};
  assign sl_w       = s_ext + {1'b0, l_i};

  always_comb begin
    if (kind_i == fel_pkg::KIND_FREE) begin
      hit_nxt = valid_i && ((IDX == 0) || (s_ext >= prev_end_w)) &&
                (sl_w <= {2'b00, start_r});
    end else begin
      hit_nxt = valid_i && (s_i >= start_r) && (s_ext <= end_w);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.cmp) begin
      hit_r <= hit_nxt;
    end
  end

  // first match along the row
  assign sel_o   = hit_r && !found_i;
  assign found_o = found_i || hit_r;
  assign start_o = start_r;
  assign len_o   = len_r;

  always_ff @(posedge clk) begin
    if (ctl_i.init) begin
      if (IDX == 0) begin
        start_r <= '0;
        len_r   <= init_len_i;
      end
    end else if (ctl_i.apply) begin
      if (cmd_i.op == fel_pkg::OP_DEL && MY_IDX >= op_idx_i) begin
        start_r <= next_start_i;
        len_r   <= next_len_i;
      end else if (cmd_i.op == fel_pkg::OP_INS && MY_IDX > op_idx_i) begin
        start_r <= prev_start_i;
        len_r   <= prev_len_i;
      end else if (cmd_i.op == fel_pkg::OP_INS && MY_IDX == op_idx_i) begin
        start_r <= ins_start_i;
        len_r   <= ins_len_i;
      end else if (cmd_i.wr_en && MY_IDX == wr_idx_i) begin
        start_r <= wr_start_i;
        len_r   <= wr_len_i;
      end
    end
  end

endmodule

/* bench/free_extent_list_manager_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_extent_list_manager_tb: self-checking bench of the free extent list
// Drives allocate and free requests against a local model of the sorted free
// list, checks status and extent count of every result in order.
// ----------------------------------------------------------------------------
module free_extent_list_manager_tb;

  localparam int NEXT = 64;
  localparam int AB   = 24;
  localparam logic [AB:0] LEN_MAX = {(AB+1){1'b1}};

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] count;
  } fel_result_t;

  class extent_scoreboard;
    logic [AB:0]   ext_base[NEXT];
    logic [AB:0]   ext_len[NEXT];
    int            ext_cnt;
    fel_result_t   pending[$];
    int            mismatches;
    int            checked;
    int            n_status[4];

    function void load_size(logic [AB:0] sz);
      ext_base[0] = '0;
      ext_len[0] = sz;
      ext_cnt = 1;
    endfunction

    function logic [AB:0] sat(logic [AB+2:0] v);
      return (v > LEN_MAX) ? LEN_MAX : v[AB:0];
    endfunction

    function void insert_at(int pos, logic [AB+1:0] s, logic [AB+2:0] l);
      for (int k = ext_cnt; k > pos; k--) begin
        ext_base[k] = ext_base[k-1];
        ext_len[k] = ext_len[k-1];
      end
      ext_base[pos] = {1'b0, s[AB-1:0]};
      ext_len[pos] = sat(l);
      ext_cnt++;
    endfunction

    function void remove_at(int pos);
      for (int k = pos; k + 1 < ext_cnt; k++) begin
        ext_base[k] = ext_base[k+1];
        ext_len[k] = ext_len[k+1];
      end
      ext_cnt--;
    endfunction

    function logic [1:0] carve(logic [AB+2:0] s, logic [AB+2:0] l);
      logic [AB+2:0] cs, ce;
      for (int i = 0; i < ext_cnt; i++) begin
        cs = (AB+3)'(ext_base[i]);
        ce = cs + (AB+3)'(ext_len[i]);
        if (s >= cs && s <= ce) begin
          if (ce < s + l) return fel_pkg::ST_OVERRUN;
          if (s == cs && l == ext_len[i]) remove_at(i);
          else if (s == cs) begin
            ext_base[i] = {1'b0, s[AB-1:0] + l[AB-1:0]};
            ext_len[i] = ext_len[i] - l[AB:0];
          end else if (s + l == ce) ext_len[i] = (AB+1)'(s - cs);
          else begin
            if (ext_cnt >= NEXT) return fel_pkg::ST_FULL;
            insert_at(i + 1, (AB+2)'(s + l), ce - s - l);
            ext_len[i] = (AB+1)'(s - cs);
          end
          return fel_pkg::ST_OK;
        end
      end
      return fel_pkg::ST_MISS;
    endfunction

    function logic [1:0] release_region(logic [AB+2:0] s, logic [AB+2:0] l);
      logic after_prev, mprev, mnext;
      logic [AB+2:0] pend;
      for (int i = 0; i < ext_cnt; i++) begin
        pend = (i > 0) ? (AB+3)'(ext_base[i-1]) + (AB+3)'(ext_len[i-1]) : '0;
        after_prev = (i == 0) || s >= pend;
        if (after_prev && s + l <= ext_base[i]) begin
          mprev = (i > 0) && s == pend;
          mnext = (s + l == ext_base[i]);
          if (mprev && mnext) begin
            ext_len[i-1] = sat(ext_len[i-1] + l + ext_len[i]);
            remove_at(i);
          end else if (mprev) ext_len[i-1] = sat(ext_len[i-1] + l);
          else if (mnext) begin
            ext_base[i] = (AB+1)'(s);
            ext_len[i] = sat(ext_len[i] + l);
          end else begin
            if (ext_cnt >= NEXT) return fel_pkg::ST_FULL;
            insert_at(i, (AB+2)'(s), l);
          end
          return fel_pkg::ST_OK;
        end
      end
      if (ext_cnt > 0 && s == ext_base[ext_cnt-1] + ext_len[ext_cnt-1]) begin
        ext_len[ext_cnt-1] = sat(ext_len[ext_cnt-1] + l);
        return fel_pkg::ST_OK;
      end
      if (ext_cnt >= NEXT) return fel_pkg::ST_FULL;
      insert_at(ext_cnt, (AB+2)'(s), l);
      return fel_pkg::ST_OK;
    endfunction

    function void note_request(logic kind, logic [AB-1:0] s, logic [AB:0] l);
      fel_result_t r;
      r.status = (kind == fel_pkg::KIND_FREE) ?
                 release_region((AB+3)'(s), (AB+3)'(l)) : carve((AB+3)'(s), (AB+3)'(l));
      r.count = ext_cnt[6:0];
      n_status[r.status]++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [6:0] cnt);
      fel_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: st=%0d cnt=%0d", st, cnt);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.status !== st || e.count !== cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: expected st=%0d cnt=%0d, got st=%0d cnt=%0d",
                   checked, e.status, e.count, st, cnt);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_kind = 0;
  logic [AB-1:0] in_start_address = '0;
  logic [AB:0] in_region_length = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [6:0] out_free_extent_count;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [AB:0] cfg_memory_size = '0;

  extent_scoreboard sb = new();
  int burst_left = 0;

  always #6 clk = ~clk;

  free_extent_list_manager u_top (
    .clk, .rst_n, .start, .busy, .in_kind, .in_start_address, .in_region_length,
    .out_valid, .out_status, .out_free_extent_count,
    .cfg_valid, .cfg_ready, .cfg_memory_size
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_free_extent_count);
  end

  task automatic send_request(logic kind, logic [AB-1:0] s, logic [AB:0] l);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_kind <= kind;
    in_start_address <= s;
    in_region_length <= l;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_request(kind, s, l);
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_size(logic [AB:0] sz);
    drain();
    cfg_memory_size <= sz;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.load_size(sz);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // pick a request that mostly touches current extents, with some noise
  task automatic random_request(logic [AB:0] span);
    int pick;
    logic [AB+1:0] cs, ln;
    logic [AB-1:0] s;
    logic [AB:0] l;
    pick = $urandom_range(0, 99);
    if (sb.ext_cnt > 0 && pick < 55) begin
      pick = $urandom_range(0, sb.ext_cnt - 1);
      cs = (AB+2)'(sb.ext_base[pick]);
      ln = (AB+2)'(sb.ext_len[pick]);
      s = AB'(cs + ((ln > 0) ? (AB+2)'($urandom_range(0, ln)) : '0));
      l = (AB+1)'($urandom_range(0, 3) == 0 ? ln :
                  (cs + ln - (AB+2)'(s)) / (AB+2)'($urandom_range(1, 4)));
      send_request(fel_pkg::KIND_ALLOC, s, l);
    end else if (pick < 90) begin
      s = AB'($urandom_range(0, span));
      l = (AB+1)'($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) :
                  $urandom_range(0, span / 8));
      send_request(fel_pkg::KIND_FREE, s, l);
    end else begin
      send_request(1'($urandom_range(0, 1)), AB'($urandom()), (AB+1)'($urandom()));
    end
  endtask

  initial begin
    #2_000_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [AB:0] spans[4];
    sb.load_size(25'd16777216);
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed corners
    send_request(fel_pkg::KIND_ALLOC, 24'd0, 25'd16);
    send_request(fel_pkg::KIND_ALLOC, 24'd100, 25'd50);
    send_request(fel_pkg::KIND_ALLOC, 24'd16, 25'd84);
    send_request(fel_pkg::KIND_ALLOC, 24'd0, 25'd5);
    send_request(fel_pkg::KIND_ALLOC, 24'd200, 25'h1FFFFFF);
    send_request(fel_pkg::KIND_ALLOC, 24'd16777215, 25'd1);
    send_request(fel_pkg::KIND_ALLOC, 24'd150, 25'd0);
    send_request(fel_pkg::KIND_FREE, 24'd16, 25'd84);
    send_request(fel_pkg::KIND_FREE, 24'd0, 25'd16);
    send_request(fel_pkg::KIND_FREE, 24'd100, 25'd50);
    send_request(fel_pkg::KIND_FREE, 24'd10, 25'd20);
    send_request(fel_pkg::KIND_FREE, 24'hFFFFFF, 25'h1FFFFFF);
    send_request(fel_pkg::KIND_ALLOC, 24'hFFFFFF, 25'd0);
    write_size('0);
    send_request(fel_pkg::KIND_ALLOC, 24'd0, 25'd0);
    send_request(fel_pkg::KIND_ALLOC, 24'd0, 25'd0);
    send_request(fel_pkg::KIND_FREE, 24'd8, 25'd8);
    send_request(fel_pkg::KIND_FREE, 24'd0, 25'd8);
    write_size(25'd1024);
    // fill the table with single-unit holes until full
    for (int i = 0; i < 70; i++) send_request(fel_pkg::KIND_ALLOC, 24'(2 * i + 1), 25'd1);
    send_request(fel_pkg::KIND_FREE, 24'd500, 25'd3);
    spans = '{25'd256, 25'd4096, 25'h1FFFFFF, 25'd16777216};
    for (int ph = 0; ph < 4; ph++) begin
      write_size(spans[ph]);
      for (int n = 0; n < 90; n++)
        random_request(spans[ph] > 25'd16777215 ? 25'd16777215 : spans[ph]);
    end
    drain();
    $display("covered %0d results: ok %0d, overrun %0d, miss %0d, full %0d",
             sb.checked, sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
